### rtl/core/lcp_pkg.sv
// ----------------------------------------------------------------------------
// lcp_pkg
// Shared types, constants and word tables of the line command parser.
// ----------------------------------------------------------------------------
package lcp_pkg;

   // field and register widths
   localparam int BYTE_W     = 8;
   localparam int FIELD_W    = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // default width of the line and payload counters
   localparam int DEFAULT_LENGTH_BITS = 16;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_LINE       = 3'd0,
      CSR_MAX_SERIAL     = 3'd1,
      CSR_THEME_SENDFILE = 3'd2,
      CSR_THEME_PERF     = 3'd3,
      CSR_THEME_PROBE    = 3'd4
   } csr_reg_type;

   // register reset values
   localparam logic [CSR_DATA_W-1:0] MAX_LINE_RST       = 16'd1024;
   localparam logic [CSR_DATA_W-1:0] MAX_SERIAL_RST     = 16'd64;
   localparam logic [CSR_DATA_W-1:0] THEME_SENDFILE_RST = 16'd0;
   localparam logic [CSR_DATA_W-1:0] THEME_PERF_RST     = 16'd1;
   localparam logic [CSR_DATA_W-1:0] THEME_PROBE_RST    = 16'd2;

   // line parse phase
   typedef enum logic [1:0] {
      PH_WORD    = 2'd0,
      PH_SERIAL  = 2'd1,
      PH_PAYLOAD = 2'd2,
      PH_SKIP    = 2'd3
   } phase_type;

   // result kinds and report status
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_REPORT  = 1'b1;
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_BAD   = 1'b1;

   // characters
   localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_SP   = 8'h20;
   localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NINE = 8'h39;

   // command words
   localparam int NUM_WORDS   = 5;
   localparam int WORD_SF     = 0;
   localparam int WORD_SENDF  = 1;
   localparam int WORD_PERF   = 2;
   localparam int WORD_PERFM  = 3;
   localparam int WORD_PROBE  = 4;
   localparam int TEXT_W      = 88;
   localparam int POS_W       = 4;
   localparam logic [POS_W-1:0] POS_MAX = 4'd15;
   localparam logic [NUM_WORDS-1:0] WORD_ALL = 5'b11111;

   typedef enum logic [1:0] {
      THEME_SENDFILE = 2'd0,
      THEME_PERF     = 2'd1,
      THEME_PROBE    = 2'd2
   } theme_sel_type;

   // length of a command word
   function automatic logic [POS_W-1:0] word_len(input int idx);
      logic [POS_W-1:0] len;
      case (idx)
         WORD_SF:    len = 4'd2;
         WORD_SENDF: len = 4'd8;
         WORD_PERF:  len = 4'd4;
         WORD_PERFM: len = 4'd11;
         default:    len = 4'd5;
      endcase
      return len;
   endfunction

   // theme register a command word maps to
   function automatic theme_sel_type word_theme(input int idx);
      theme_sel_type sel;
      case (idx)
         WORD_SF, WORD_SENDF: sel = THEME_SENDFILE;
         WORD_PERF, WORD_PERFM: sel = THEME_PERF;
         default: sel = THEME_PROBE;
      endcase
      return sel;
   endfunction

   // character at a position of a command word, zero past its end
   function automatic logic [BYTE_W-1:0] word_char(input int idx,
                                                   input logic [POS_W-1:0] pos);
      logic [TEXT_W-1:0] text;
      logic [POS_W-1:0]  len;
      logic [POS_W-1:0]  back;
      logic [BYTE_W-1:0] ch;
      case (idx)
         WORD_SF:    text = TEXT_W'("sf");
         WORD_SENDF: text = TEXT_W'("sendfile");
         WORD_PERF:  text = TEXT_W'("perf");
         WORD_PERFM: text = TEXT_W'("performance");
         default:    text = TEXT_W'("probe");
      endcase
      len  = word_len(idx);
      back = len - pos - 4'd1;
      ch   = '0;
      if (pos < len) begin
         ch = text[{back, 3'b000} +: BYTE_W];
      end
      return ch;
   endfunction

endpackage

### rtl/core/lcp_req_if.sv
// ----------------------------------------------------------------------------
// lcp_req_if
// Input byte channel: valid/ready handshake with one text byte per item.
// ----------------------------------------------------------------------------
interface lcp_req_if;
   logic                        valid;
   logic                        ready;
   logic [lcp_pkg::BYTE_W-1:0]  in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

### rtl/core/lcp_rsp_if.sv
// ----------------------------------------------------------------------------
// lcp_rsp_if
// Result channel: payload bytes and end-of-line reports.
// ----------------------------------------------------------------------------
interface lcp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        kind;
   logic [lcp_pkg::BYTE_W-1:0]  payload_byte;
   logic                        status;
   logic [lcp_pkg::FIELD_W-1:0] theme_code;
   logic [lcp_pkg::FIELD_W-1:0] serial_value;
   logic [lcp_pkg::FIELD_W-1:0] record_length;

   modport source (output valid, output kind, output payload_byte, output status,
                   output theme_code, output serial_value, output record_length,
                   input ready);
   modport sink   (input valid, input kind, input payload_byte, input status,
                   input theme_code, input serial_value, input record_length,
                   output ready);
endinterface

### rtl/core/line_command_parser_unit.sv
// ----------------------------------------------------------------------------
// line_command_parser_unit
// Streaming parser for "word serial [payload]" command lines.
// ----------------------------------------------------------------------------
// Takes one text byte per cycle as long as the result side keeps up and
// yields at most one item per byte: a payload byte, or a report at the end
// of a line (LF, CR or CRLF; empty lines give nothing). A byte is held in an
// input register, then the word match, the decimal serial step and the length
// check run in one pass into the result register. A report with status 1
// means the line was bad or reached max_line bytes; drop its payload bytes.
// Registers must be written by the user through the csr port only while the
// block is idle; the block itself does not enforce it.
module line_command_parser_unit #(
   parameter int LENGTH_BITS = lcp_pkg::DEFAULT_LENGTH_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [lcp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lcp_pkg::CSR_DATA_W-1:0]   csr_write_data,
   lcp_req_if.sink                          req_chan,
   lcp_rsp_if.source                        rsp_chan
);

   localparam int CW = (LENGTH_BITS > lcp_pkg::FIELD_W) ? LENGTH_BITS : lcp_pkg::FIELD_W;
   localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
   localparam logic [CW-1:0] LEN_MAX_W = CW'(LEN_MAX);
   localparam int SER_W = lcp_pkg::FIELD_W + 4;

   // configuration registers
   logic [lcp_pkg::CSR_DATA_W-1:0] max_line_ff;
   logic [lcp_pkg::CSR_DATA_W-1:0] max_serial_ff;
   logic [lcp_pkg::CSR_DATA_W-1:0] theme_sendfile_ff;
   logic [lcp_pkg::CSR_DATA_W-1:0] theme_perf_ff;
   logic [lcp_pkg::CSR_DATA_W-1:0] theme_probe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_line_ff       <= lcp_pkg::MAX_LINE_RST;
         max_serial_ff     <= lcp_pkg::MAX_SERIAL_RST;
         theme_sendfile_ff <= lcp_pkg::THEME_SENDFILE_RST;
         theme_perf_ff     <= lcp_pkg::THEME_PERF_RST;
         theme_probe_ff    <= lcp_pkg::THEME_PROBE_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            lcp_pkg::CSR_MAX_LINE:       max_line_ff       <= csr_write_data;
            lcp_pkg::CSR_MAX_SERIAL:     max_serial_ff     <= csr_write_data;
            lcp_pkg::CSR_THEME_SENDFILE: theme_sendfile_ff <= csr_write_data;
            lcp_pkg::CSR_THEME_PERF:     theme_perf_ff     <= csr_write_data;
            lcp_pkg::CSR_THEME_PROBE:    theme_probe_ff    <= csr_write_data;
            default: ;
         endcase
      end
   end

   // input register and handshake
   logic                        s1_valid_ff;
   logic [lcp_pkg::BYTE_W-1:0]  s1_byte_ff;
   logic                        rsp_valid_ff;
   logic                        advance;

   assign advance        = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         s1_byte_ff <= req_chan.in_byte;
      end
   end

   // line state
   lcp_pkg::phase_type             phase_ff, phase_in;
   logic [LENGTH_BITS-1:0]         line_count_ff, line_count_in;
   logic [lcp_pkg::NUM_WORDS-1:0]  word_mask_ff, word_mask_in;
   logic [lcp_pkg::POS_W-1:0]      word_pos_ff, word_pos_in;
   logic [lcp_pkg::FIELD_W-1:0]    latched_theme_ff, latched_theme_in;
   logic [lcp_pkg::FIELD_W-1:0]    serial_accum_ff, serial_accum_in;
   logic                           serial_has_digit_ff, serial_has_digit_in;
   logic                           line_bad_ff, line_bad_in;
   logic [LENGTH_BITS-1:0]         payload_count_ff, payload_count_in;
   logic                           after_cr_ff, after_cr_in;

   // result of the current byte
   logic                           res_valid;
   logic                           res_kind;
   logic [lcp_pkg::BYTE_W-1:0]     res_byte;
   logic                           res_status;
   logic [lcp_pkg::FIELD_W-1:0]    res_theme;
   logic [lcp_pkg::FIELD_W-1:0]    res_serial;
   logic [lcp_pkg::FIELD_W-1:0]    res_length;

   // size limit, capped at what the counter can hold
   logic [CW-1:0]                  max_line_w;
   logic [CW-1:0]                  limit;
   assign max_line_w = CW'(max_line_ff);
   assign limit      = (max_line_w < LEN_MAX_W) ? max_line_w : LEN_MAX_W;

   // report length is payload count plus one
   logic [CW:0]                    plen;
   assign plen = (CW + 1)'(payload_count_ff) + (CW + 1)'(1);

   // parse step
   always_comb begin
      logic [lcp_pkg::BYTE_W-1:0] c;
      logic [LENGTH_BITS-1:0]     count_inc;
      logic                       restart;
      logic                       ok;
      logic                       found;
      logic [SER_W-1:0]           ser_next;

      c         = s1_byte_ff;
      restart   = 1'b0;
      ok        = 1'b0;
      found     = 1'b0;
      count_inc = (line_count_ff == LEN_MAX) ? line_count_ff
                                             : line_count_ff + LENGTH_BITS'(1);
      ser_next  = (SER_W'(serial_accum_ff) << 3) + (SER_W'(serial_accum_ff) << 1)
                + SER_W'(c - lcp_pkg::CH_ZERO);

      phase_in            = phase_ff;
      line_count_in       = line_count_ff;
      word_mask_in        = word_mask_ff;
      word_pos_in         = word_pos_ff;
      latched_theme_in    = latched_theme_ff;
      serial_accum_in     = serial_accum_ff;
      serial_has_digit_in = serial_has_digit_ff;
      line_bad_in         = line_bad_ff;
      payload_count_in    = payload_count_ff;
      after_cr_in         = 1'b0;

      res_valid  = 1'b0;
      res_kind   = lcp_pkg::KIND_PAYLOAD;
      res_byte   = '0;
      res_status = lcp_pkg::STATUS_OK;
      res_theme  = '0;
      res_serial = '0;
      res_length = '0;

      if (after_cr_ff && c == lcp_pkg::CH_LF) begin
         // LF of a CRLF pair: absorbed
      end else if (c == lcp_pkg::CH_LF || c == lcp_pkg::CH_CR) begin
         // end of line
         after_cr_in = (c == lcp_pkg::CH_CR);
         restart     = 1'b1;
         if (line_count_ff != '0) begin
            case (phase_ff)
               lcp_pkg::PH_PAYLOAD: ok = !line_bad_ff;
               lcp_pkg::PH_SERIAL:  ok = !line_bad_ff && serial_has_digit_ff;
               default:             ok = 1'b0;
            endcase
            res_valid  = 1'b1;
            res_kind   = lcp_pkg::KIND_REPORT;
            res_status = ok ? lcp_pkg::STATUS_OK : lcp_pkg::STATUS_BAD;
            res_theme  = ok ? latched_theme_ff : '0;
            res_serial = ok ? serial_accum_ff : '0;
            res_length = ok ? plen[lcp_pkg::FIELD_W-1:0] : '0;
         end
      end else begin
         line_count_in = count_inc;
         if (CW'(count_inc) >= limit) begin
            // oversized line
            res_valid  = 1'b1;
            res_kind   = lcp_pkg::KIND_REPORT;
            res_status = lcp_pkg::STATUS_BAD;
            restart    = 1'b1;
         end else begin
            case (phase_ff)
               lcp_pkg::PH_WORD: begin
                  if (c == lcp_pkg::CH_SP) begin
                     // close the word
                     if (word_pos_ff != '0) begin
                        for (int i = 0; i < lcp_pkg::NUM_WORDS; i++) begin
                           if (!found && word_mask_ff[i] &&
                               lcp_pkg::word_len(i) == word_pos_ff) begin
                              found = 1'b1;
                              case (lcp_pkg::word_theme(i))
                                 lcp_pkg::THEME_SENDFILE: latched_theme_in = theme_sendfile_ff;
                                 lcp_pkg::THEME_PERF:     latched_theme_in = theme_perf_ff;
                                 default:                 latched_theme_in = theme_probe_ff;
                              endcase
                           end
                        end
                     end
                     if (found) begin
                        phase_in = lcp_pkg::PH_SERIAL;
                     end else begin
                        line_bad_in = 1'b1;
                        phase_in    = lcp_pkg::PH_SKIP;
                     end
                  end else begin
                     // narrow the candidate words
                     for (int i = 0; i < lcp_pkg::NUM_WORDS; i++) begin
                        if (!(word_pos_ff < lcp_pkg::word_len(i) &&
                              lcp_pkg::word_char(i, word_pos_ff) == c)) begin
                           word_mask_in[i] = 1'b0;
                        end
                     end
                     if (word_pos_ff < lcp_pkg::POS_MAX) begin
                        word_pos_in = word_pos_ff + 4'd1;
                     end
                  end
               end
               lcp_pkg::PH_SERIAL: begin
                  if (c == lcp_pkg::CH_SP) begin
                     if (serial_has_digit_ff) begin
                        phase_in = lcp_pkg::PH_PAYLOAD;
                     end else begin
                        line_bad_in = 1'b1;
                        phase_in    = lcp_pkg::PH_SKIP;
                     end
                  end else if (c inside {[lcp_pkg::CH_ZERO:lcp_pkg::CH_NINE]}) begin
                     if (ser_next > SER_W'(max_serial_ff)) begin
                        line_bad_in = 1'b1;
                        phase_in    = lcp_pkg::PH_SKIP;
                     end else begin
                        serial_accum_in     = ser_next[lcp_pkg::FIELD_W-1:0];
                        serial_has_digit_in = 1'b1;
                     end
                  end else begin
                     line_bad_in = 1'b1;
                     phase_in    = lcp_pkg::PH_SKIP;
                  end
               end
               lcp_pkg::PH_PAYLOAD: begin
                  if (payload_count_ff != LEN_MAX) begin
                     payload_count_in = payload_count_ff + LENGTH_BITS'(1);
                  end
                  res_valid = 1'b1;
                  res_kind  = lcp_pkg::KIND_PAYLOAD;
                  res_byte  = c;
               end
               default: ;
            endcase
         end
      end

      // fresh line
      if (restart) begin
         phase_in            = lcp_pkg::PH_WORD;
         line_count_in       = '0;
         word_mask_in        = lcp_pkg::WORD_ALL;
         word_pos_in         = '0;
         latched_theme_in    = '0;
         serial_accum_in     = '0;
         serial_has_digit_in = 1'b0;
         line_bad_in         = 1'b0;
         payload_count_in    = '0;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff            <= lcp_pkg::PH_WORD;
         line_count_ff       <= '0;
         word_mask_ff        <= lcp_pkg::WORD_ALL;
         word_pos_ff         <= '0;
         latched_theme_ff    <= '0;
         serial_accum_ff     <= '0;
         serial_has_digit_ff <= 1'b0;
         line_bad_ff         <= 1'b0;
         payload_count_ff    <= '0;
         after_cr_ff         <= 1'b0;
      end else if (advance) begin
         phase_ff            <= phase_in;
         line_count_ff       <= line_count_in;
         word_mask_ff        <= word_mask_in;
         word_pos_ff         <= word_pos_in;
         latched_theme_ff    <= latched_theme_in;
         serial_accum_ff     <= serial_accum_in;
         serial_has_digit_ff <= serial_has_digit_in;
         line_bad_ff         <= line_bad_in;
         payload_count_ff    <= payload_count_in;
         after_cr_ff         <= after_cr_in;
      end
   end

   // result register
   logic                        rsp_kind_ff;
   logic [lcp_pkg::BYTE_W-1:0]  rsp_byte_ff;
   logic                        rsp_status_ff;
   logic [lcp_pkg::FIELD_W-1:0] rsp_theme_ff;
   logic [lcp_pkg::FIELD_W-1:0] rsp_serial_ff;
   logic [lcp_pkg::FIELD_W-1:0] rsp_length_ff;
   logic                        rsp_valid_in;

   assign rsp_valid_in = advance ? res_valid : (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         rsp_kind_ff   <= res_kind;
         rsp_byte_ff   <= res_byte;
         rsp_status_ff <= res_status;
         rsp_theme_ff  <= res_theme;
         rsp_serial_ff <= res_serial;
         rsp_length_ff <= res_length;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.kind          = rsp_kind_ff;
   assign rsp_chan.payload_byte  = rsp_byte_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.theme_code    = rsp_theme_ff;
   assign rsp_chan.serial_value  = rsp_serial_ff;
   assign rsp_chan.record_length = rsp_length_ff;

   // checks
   a_fresh_line_in_word: assert property (@(posedge clock) disable iff (reset)
      (line_count_ff == '0) |-> (phase_ff == lcp_pkg::PH_WORD))
      else $error("empty line left the word phase");

   a_payload_only_in_payload: assert property (@(posedge clock) disable iff (reset)
      (payload_count_ff != '0) |-> (phase_ff == lcp_pkg::PH_PAYLOAD))
      else $error("payload counted outside the payload phase");

   a_bad_report_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == lcp_pkg::KIND_REPORT &&
       rsp_status_ff == lcp_pkg::STATUS_BAD)
      |-> (rsp_length_ff == '0 && rsp_theme_ff == '0 && rsp_serial_ff == '0))
      else $error("invalid report carries line data");

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the line command parser. Streams directed and
// random command text through the byte channel under random gaps and
// back-pressure, predicts every payload byte and line report, and compares
// each item on the result channel against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import lcp_pkg::*;

   localparam int LINE_COUNT_MAX = (1 << DEFAULT_LENGTH_BITS) - 1;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int DRAIN_CYCLES   = 6;
   localparam int MISMATCH_SHOWN = 10;
   localparam int RANDOM_PHASES  = 5;
   localparam int PHASE_BYTES    = 190;
   localparam int STEADY_BYTES   = 300;
   localparam logic [BYTE_W-1:0] CH_LOWER_A = 8'h61;
   localparam logic [BYTE_W-1:0] CH_LOWER_Z = 8'h7A;

   typedef enum int {
      END_NONE,
      END_LF,
      END_CR,
      END_CRLF
   } line_end_type;

   typedef struct packed {
      logic               kind;
      logic [BYTE_W-1:0]  payload_byte;
      logic               status;
      logic [FIELD_W-1:0] theme_code;
      logic [FIELD_W-1:0] serial_value;
      logic [FIELD_W-1:0] record_length;
   } parser_item_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   lcp_req_if req_chan ();
   lcp_rsp_if rsp_chan ();

   line_command_parser_unit dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan)
   );

   // command words and the theme register each one reports
   string         cmd_words  [NUM_WORDS] = '{"sf", "sendfile", "perf", "performance", "probe"};
   theme_sel_type cmd_themes [NUM_WORDS] = '{THEME_SENDFILE, THEME_SENDFILE, THEME_PERF,
                                             THEME_PERF, THEME_PROBE};

   // register copies
   logic [CSR_DATA_W-1:0] max_line_reg;
   logic [CSR_DATA_W-1:0] max_serial_reg;
   logic [CSR_DATA_W-1:0] theme_reg [3];

   // line state of the parser as the bench sees it
   phase_type            pr_phase;
   int unsigned          pr_count;
   int unsigned          pr_pos;
   int unsigned          pr_serial;
   int unsigned          pr_payload;
   logic [NUM_WORDS-1:0] pr_mask;
   logic [FIELD_W-1:0]   pr_theme;
   bit                   pr_has_digit;
   bit                   pr_bad;
   bit                   pr_after_cr;

   parser_item_type   line_outputs [$];
   logic [BYTE_W-1:0] tx_bytes [$];

   int mismatch_count = 0;
   int cycle_count    = 0;
   int gap_pct        = 30;
   int stall_pct      = 30;

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // line parser prediction
   // ------------------------------------------------------------------------
   function automatic void restart_line_state();
      pr_phase     = PH_WORD;
      pr_count     = 0;
      pr_mask      = WORD_ALL;
      pr_pos       = 0;
      pr_theme     = '0;
      pr_serial    = 0;
      pr_has_digit = 1'b0;
      pr_bad       = 1'b0;
      pr_payload   = 0;
   endfunction

   function automatic void skip_line();
      pr_bad   = 1'b1;
      pr_phase = PH_SKIP;
   endfunction

   function automatic void push_report(input bit ok);
      parser_item_type rpt;
      rpt = '{KIND_REPORT, 8'd0, STATUS_BAD, 16'd0, 16'd0, 16'd0};
      if (ok) begin
         rpt.status        = STATUS_OK;
         rpt.theme_code    = pr_theme;
         rpt.serial_value  = FIELD_W'(pr_serial);
         rpt.record_length = FIELD_W'(pr_payload + 1);
      end
      line_outputs.push_back(rpt);
   endfunction

   function automatic void parse_byte(input logic [BYTE_W-1:0] c);
      int unsigned limit;
      int unsigned next;
      bit          found;
      limit = (max_line_reg < LINE_COUNT_MAX) ? max_line_reg : LINE_COUNT_MAX;
      // LF right after CR belongs to the CR
      if (pr_after_cr && c == CH_LF) begin
         pr_after_cr = 1'b0;
         return;
      end
      pr_after_cr = (c == CH_CR);
      if (c == CH_LF || c == CH_CR) begin
         // empty lines give nothing
         if (pr_count != 0) begin
            push_report((pr_phase == PH_PAYLOAD && !pr_bad) ||
                        (pr_phase == PH_SERIAL && !pr_bad && pr_has_digit));
         end
         restart_line_state();
         return;
      end
      if (pr_count < LINE_COUNT_MAX) pr_count++;
      // oversized: report now and parse the rest as a fresh line
      if (pr_count >= limit) begin
         push_report(1'b0);
         restart_line_state();
         return;
      end
      case (pr_phase)
         PH_WORD: begin
            if (c == CH_SP) begin
               found = 1'b0;
               for (int i = 0; i < NUM_WORDS; i++) begin
                  if (pr_mask[i] && cmd_words[i].len() == pr_pos) begin
                     pr_theme = theme_reg[cmd_themes[i]];
                     found    = 1'b1;
                  end
               end
               if (found) pr_phase = PH_SERIAL;
               else skip_line();
            end else begin
               for (int i = 0; i < NUM_WORDS; i++) begin
                  if (!(pr_pos < cmd_words[i].len() && cmd_words[i][pr_pos] == c)) begin
                     pr_mask[i] = 1'b0;
                  end
               end
               if (pr_pos < POS_MAX) pr_pos++;
            end
         end
         PH_SERIAL: begin
            if (c == CH_SP) begin
               if (pr_has_digit) pr_phase = PH_PAYLOAD;
               else skip_line();
            end else if (c >= CH_ZERO && c <= CH_NINE) begin
               next = pr_serial * 10 + (c - CH_ZERO);
               if (next > max_serial_reg) begin
                  skip_line();
               end else begin
                  pr_serial    = next;
                  pr_has_digit = 1'b1;
               end
            end else begin
               skip_line();
            end
         end
         PH_PAYLOAD: begin
            if (pr_payload < LINE_COUNT_MAX) pr_payload++;
            line_outputs.push_back('{KIND_PAYLOAD, c, STATUS_OK, 16'd0, 16'd0, 16'd0});
         end
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------------
   // one byte item, with random gaps ahead of it
   task automatic send_byte(input logic [BYTE_W-1:0] value);
      while ($urandom_range(99) < gap_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.in_byte <= value;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      parse_byte(value);
      @(negedge clock);
   endtask

   task automatic flush_tx();
      while (tx_bytes.size() != 0) send_byte(tx_bytes.pop_front());
   endtask

   function automatic void push_text(input string s);
      for (int i = 0; i < s.len(); i++) tx_bytes.push_back(s[i]);
   endfunction

   function automatic void push_line_end(input line_end_type term);
      case (term)
         END_LF:   tx_bytes.push_back(CH_LF);
         END_CR:   tx_bytes.push_back(CH_CR);
         END_CRLF: begin
            tx_bytes.push_back(CH_CR);
            tx_bytes.push_back(CH_LF);
         end
         default: ;
      endcase
   endfunction

   task automatic send_line(input string body, input line_end_type term);
      push_text(body);
      push_line_end(term);
      flush_tx();
   endtask

   // stop sending and let every predicted item drain out
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (line_outputs.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input csr_reg_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
      case (idx)
         CSR_MAX_LINE:       max_line_reg = value;
         CSR_MAX_SERIAL:     max_serial_reg = value;
         CSR_THEME_SENDFILE: theme_reg[THEME_SENDFILE] = value;
         CSR_THEME_PERF:     theme_reg[THEME_PERF] = value;
         CSR_THEME_PROBE:    theme_reg[THEME_PROBE] = value;
         default: ;
      endcase
   endtask

   task automatic write_config(input logic [CSR_DATA_W-1:0] line_max,
                               input logic [CSR_DATA_W-1:0] serial_max,
                               input logic [CSR_DATA_W-1:0] th_sendfile,
                               input logic [CSR_DATA_W-1:0] th_perf,
                               input logic [CSR_DATA_W-1:0] th_probe);
      wait_idle();
      write_reg(CSR_MAX_LINE, line_max);
      write_reg(CSR_MAX_SERIAL, serial_max);
      write_reg(CSR_THEME_SENDFILE, th_sendfile);
      write_reg(CSR_THEME_PERF, th_perf);
      write_reg(CSR_THEME_PROBE, th_probe);
   endtask

   // random command line: mostly well-formed, some damaged, some pure noise
   function automatic void compose_line();
      int unsigned pick;
      int unsigned w;
      int unsigned n;
      int unsigned damage;
      int unsigned spot;
      int unsigned cut;
      int unsigned value;
      logic [BYTE_W-1:0] b;
      string digits;
      pick = $urandom_range(99);
      if (pick < 8) begin
         // arbitrary bytes, terminators included
         n = $urandom_range(1, 12);
         repeat (n) tx_bytes.push_back(BYTE_W'($urandom_range(255)));
      end else begin
         // command word, damaged now and then
         w      = $urandom_range(NUM_WORDS - 1);
         damage = ($urandom_range(99) < 12) ? $urandom_range(1, 4) : 0;
         cut    = cmd_words[w].len();
         spot   = $urandom_range(cut - 1);
         if (damage == 1) cut = cut - 1;
         if (damage != 4) begin
            for (int i = 0; i < cut; i++) begin
               if (damage == 3 && i == spot) tx_bytes.push_back(BYTE_W'($urandom_range(255)));
               else tx_bytes.push_back(cmd_words[w][i]);
            end
         end
         if (damage == 2) tx_bytes.push_back(BYTE_W'($urandom_range(CH_LOWER_A, CH_LOWER_Z)));
         // separator
         pick = $urandom_range(99);
         if (pick >= 3) tx_bytes.push_back(CH_SP);
         if (pick >= 95) tx_bytes.push_back(CH_SP);
         // serial
         pick = $urandom_range(99);
         if (pick >= 5) begin
            if (pick < 70) value = $urandom_range(max_serial_reg);
            else if (pick < 80) value = max_serial_reg;
            else value = max_serial_reg + $urandom_range(1, 100);
            if ($urandom_range(99) < 15) repeat ($urandom_range(1, 2)) tx_bytes.push_back(CH_ZERO);
            digits = $sformatf("%0d", value);
            push_text(digits);
            if (pick >= 95) begin
               tx_bytes.push_back(BYTE_W'($urandom_range(CH_LOWER_A, CH_LOWER_Z)));
               tx_bytes.push_back(CH_ZERO);
            end
         end
         // payload, spaces and any byte but a terminator
         if ($urandom_range(99) < 70) begin
            tx_bytes.push_back(CH_SP);
            n = ($urandom_range(99) < 10) ? $urandom_range(13, 40) : $urandom_range(0, 12);
            repeat (n) begin
               b = BYTE_W'($urandom_range(255));
               if (b == CH_LF || b == CH_CR) b = CH_SP;
               tx_bytes.push_back(b);
            end
         end
      end
      // terminator; a missing one runs into the next line
      if ($urandom_range(99) < 4) push_line_end(END_NONE);
      else push_line_end(line_end_type'($urandom_range(END_LF, END_CRLF)));
   endfunction

   task automatic send_random_text(input int byte_goal);
      int sent;
      sent = 0;
      while (sent < byte_goal) begin
         compose_line();
         sent += tx_bytes.size();
         flush_tx();
      end
   endtask

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
   end

   // ------------------------------------------------------------------------
   // result check
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      parser_item_type got;
      parser_item_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = '{rsp_chan.kind, rsp_chan.payload_byte, rsp_chan.status,
                 rsp_chan.theme_code, rsp_chan.serial_value, rsp_chan.record_length};
         if (line_outputs.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MISMATCH_SHOWN) begin
               $display("item with nothing pending: kind %0d byte %02h status %0d",
                        got.kind, got.payload_byte, got.status);
            end
         end else begin
            want = line_outputs.pop_front();
            if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
                got.status !== want.status || got.theme_code !== want.theme_code ||
                got.serial_value !== want.serial_value ||
                got.record_length !== want.record_length) begin
               mismatch_count++;
               if (mismatch_count <= MISMATCH_SHOWN) begin
                  $display("mismatch at cycle %0d", cycle_count);
                  $display("  expected kind %0d byte %02h status %0d theme %0d serial %0d len %0d",
                           want.kind, want.payload_byte, want.status, want.theme_code,
                           want.serial_value, want.record_length);
                  $display("  actual   kind %0d byte %02h status %0d theme %0d serial %0d len %0d",
                           got.kind, got.payload_byte, got.status, got.theme_code,
                           got.serial_value, got.record_length);
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   // reset register values; every word, status and line ending
   task automatic test_directed_lines();
      send_line("sf 5 hi", END_LF);
      send_line("sendfile 64", END_CRLF);
      send_line("perf 0 a b ", END_CR);
      send_line("performance 65", END_LF);
      send_line("probe 007 ", END_LF);
      send_line("", END_LF);
      send_line("", END_CRLF);
      send_line(" sf 1", END_LF);
      send_line("sf", END_LF);
      send_line("sf ", END_CR);
      send_line("sf  1", END_LF);
      send_line("sf 1a", END_LF);
      send_line("sfx 1", END_LF);
      send_line("sendfil 2", END_LF);
      send_line("prob 3 x", END_LF);
      // CR CR LF: one line, one empty line, absorbed LF
      send_line("sf 2", END_CR);
      send_line("", END_CR);
      send_line("", END_LF);
      // LF after CR with bytes in between ends its own line
      send_line("perf 4", END_CR);
      send_line("probe 6", END_LF);
      // payload byte extremes
      send_line("sf 1 ", END_NONE);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(CH_LF);
   endtask

   // register extremes
   task automatic test_register_extremes();
      // every byte is an oversized line
      write_config(16'd1, 16'd64, 16'h00A5, 16'h5A00, 16'h0FF0);
      send_line("sf 1 a", END_LF);
      write_config(16'd2, 16'd64, 16'h00A5, 16'h5A00, 16'h0FF0);
      send_line("sf 1", END_CRLF);
      write_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_line("sendfile 65535 zz", END_LF);
      send_line("perf 65536", END_LF);
      send_line("probe 99999", END_LF);
      send_line("sf 00065535 ", END_CR);
      write_config(16'd1024, 16'd0, 16'd0, 16'd0, 16'd0);
      send_line("sf 0 x", END_LF);
      send_line("performance 00", END_LF);
      send_line("probe 1", END_LF);
   endtask

   // line size limit hit in the word, skip and payload phases
   task automatic test_oversized_lines();
      write_config(16'd9, 16'd64, 16'h1111, 16'h2222, 16'h3333);
      send_line("probe 1 abcdefgh", END_LF);
      send_line("xxxxxxxxxxxxxxxxxxx", END_LF);
      send_line("sf 12345678", END_CRLF);
      send_line("performance 1", END_LF);
      send_line("perf 8 ab", END_CR);
      send_line("perf 8 abc", END_LF);
   endtask

   // random lines under several register settings
   task automatic test_random_traffic();
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0: write_config(MAX_LINE_RST, MAX_SERIAL_RST,
                            CSR_DATA_W'($urandom_range(65535)),
                            CSR_DATA_W'($urandom_range(65535)),
                            CSR_DATA_W'($urandom_range(65535)));
            1: write_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            2: write_config(CSR_DATA_W'($urandom_range(6, 20)),
                            CSR_DATA_W'($urandom_range(200)),
                            CSR_DATA_W'($urandom_range(65535)),
                            CSR_DATA_W'($urandom_range(65535)),
                            CSR_DATA_W'($urandom_range(65535)));
            3: write_config(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0);
            default: write_config(CSR_DATA_W'($urandom_range(1, 65535)),
                                  CSR_DATA_W'($urandom_range(65535)),
                                  CSR_DATA_W'($urandom_range(65535)),
                                  CSR_DATA_W'($urandom_range(65535)),
                                  CSR_DATA_W'($urandom_range(65535)));
         endcase
         send_random_text(PHASE_BYTES);
      end
   endtask

   // back-to-back items with no gaps or stalls on either side
   task automatic test_steady_stream();
      write_config(16'd40, 16'd999, 16'h0101, 16'h0202, 16'h0303);
      gap_pct   = 0;
      stall_pct = 0;
      send_random_text(STEADY_BYTES);
      wait_idle();
      gap_pct   = 30;
      stall_pct = 30;
   endtask

   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = CSR_MAX_LINE;
      csr_write_data   = '0;
      req_chan.valid   = 1'b0;
      req_chan.in_byte = '0;
      rsp_chan.ready   = 1'b0;
      max_line_reg     = MAX_LINE_RST;
      max_serial_reg   = MAX_SERIAL_RST;
      theme_reg[THEME_SENDFILE] = THEME_SENDFILE_RST;
      theme_reg[THEME_PERF]     = THEME_PERF_RST;
      theme_reg[THEME_PROBE]    = THEME_PROBE_RST;
      pr_after_cr      = 1'b0;
      restart_line_state();
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      test_directed_lines();
      test_register_extremes();
      test_oversized_lines();
      test_random_traffic();
      test_steady_stream();
      wait_idle();

      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### files.f
rtl/core/lcp_pkg.sv
rtl/core/lcp_req_if.sv
rtl/core/lcp_rsp_if.sv
rtl/core/line_command_parser_unit.sv
tb/tb_top.sv
